// ===== src/e2q_pkg.sv =====
// Shared types, constants and helper functions for the Euler angle to quaternion block.
// No dependencies; every other file imports this package.
package e2q_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int OUT_WIDTH    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 34;
    localparam int Z_W          = 36;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 64;
    localparam int OUT_SHIFT    = 61 - OUT_WIDTH;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [PROD_W-1:0] OUT_LIM =
        PROD_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] quat_w;
        logic signed [OUT_WIDTH-1:0] quat_x;
        logic signed [OUT_WIDTH-1:0] quat_y;
        logic signed [OUT_WIDTH-1:0] quat_z;
    } out_word_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // Doubled arctangent of 2^-i, in units of 2^32 per turn.
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(536870912);
            1:  v = Z_W'(316933406);
            2:  v = Z_W'(167458907);
            3:  v = Z_W'(85004756);
            4:  v = Z_W'(42667331);
            5:  v = Z_W'(21354465);
            6:  v = Z_W'(10679838);
            7:  v = Z_W'(5340245);
            8:  v = Z_W'(2670163);
            9:  v = Z_W'(1335087);
            10: v = Z_W'(667544);
            11: v = Z_W'(333772);
            12: v = Z_W'(166886);
            13: v = Z_W'(83443);
            14: v = Z_W'(41722);
            15: v = Z_W'(20861);
            16: v = Z_W'(10430);
            17: v = Z_W'(5215);
            18: v = Z_W'(2608);
            19: v = Z_W'(1304);
            20: v = Z_W'(652);
            21: v = Z_W'(326);
            22: v = Z_W'(163);
            23: v = Z_W'(81);
            default: v = '0;
        endcase
        return v <<< 1;
    endfunction

    // Starting vector for one angle: the half angle, with x preloaded by the gain.
    function automatic cordic_t cordic_start(input logic signed [ANGLE_WIDTH-1:0] a);
        cordic_t c;
        c.x = CORDIC_GAIN;
        c.y = '0;
        c.z = Z_W'(a) <<< (32 - ANGLE_WIDTH);
        return c;
    endfunction

    // Round half up from Q60 and saturate symmetrically.
    function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [PROD_W-1:0] q);
        logic signed [PROD_W-1:0] v;
        v = (q + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (v > OUT_LIM)
            v = OUT_LIM;
        if (v < -OUT_LIM)
            v = -OUT_LIM;
        return v[OUT_WIDTH-1:0];
    endfunction

endpackage

// ===== src/e2q_cordic_cell.sv =====
// One rotation-mode CORDIC iteration for one angle, registered.
// Depends on e2q_pkg for the vector type and the arctangent constants.
module e2q_cordic_cell
    import e2q_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t d,
    output cordic_t q
);

    cordic_t q_reg;
    cordic_t q_next;

    always_comb
    begin
        if (d.z >= 0)
        begin
            q_next.x = d.x - (d.y >>> STEP);
            q_next.y = d.y + (d.x >>> STEP);
            q_next.z = d.z - atan_step(STEP);
        end
        else
        begin
            q_next.x = d.x + (d.y >>> STEP);
            q_next.y = d.y - (d.x >>> STEP);
            q_next.z = d.z + atan_step(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== src/e2q_quat_mul.sv =====
// Three-stage product network that forms the quaternion sums in Q60.
// Depends on e2q_pkg for widths.
module e2q_quat_mul
    import e2q_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [XY_W-1:0]   c1,
    input  logic signed [XY_W-1:0]   s1,
    input  logic signed [XY_W-1:0]   c2,
    input  logic signed [XY_W-1:0]   s2,
    input  logic signed [XY_W-1:0]   c3,
    input  logic signed [XY_W-1:0]   s3,
    output logic signed [PROD_W-1:0] sum_w,
    output logic signed [PROD_W-1:0] sum_x,
    output logic signed [PROD_W-1:0] sum_y,
    output logic signed [PROD_W-1:0] sum_z
);

    logic signed [PROD_W-1:0] pcc_reg, pss_reg, psc_reg, pcs_reg;
    logic signed [MUL_W-1:0]  c3a_reg, s3a_reg, c3b_reg, s3b_reg;
    logic signed [MUL_W-1:0]  cc_reg, ss_reg, sc_reg, cs_reg;
    logic signed [PROD_W-1:0] cc_c_reg, cc_s_reg, ss_c_reg, ss_s_reg;
    logic signed [PROD_W-1:0] sc_c_reg, sc_s_reg, cs_c_reg, cs_s_reg;
    logic signed [MUL_W-1:0]  c1n, s1n, c2n, s2n;
    logic signed [PROD_W-1:0] half;

    // Cosines and sines stay within about one in Q30, so 32 bits hold them.
    assign c1n  = c1[MUL_W-1:0];
    assign s1n  = s1[MUL_W-1:0];
    assign c2n  = c2[MUL_W-1:0];
    assign s2n  = s2[MUL_W-1:0];
    assign half = 64'sd1 <<< 29;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg  <= c1n * c2n;
            pss_reg  <= s1n * s2n;
            psc_reg  <= s1n * c2n;
            pcs_reg  <= c1n * s2n;
            c3a_reg  <= c3[MUL_W-1:0];
            s3a_reg  <= s3[MUL_W-1:0];

            cc_reg   <= MUL_W'((pcc_reg + half) >>> 30);
            ss_reg   <= MUL_W'((pss_reg + half) >>> 30);
            sc_reg   <= MUL_W'((psc_reg + half) >>> 30);
            cs_reg   <= MUL_W'((pcs_reg + half) >>> 30);
            c3b_reg  <= c3a_reg;
            s3b_reg  <= s3a_reg;

            cc_c_reg <= cc_reg * c3b_reg;
            cc_s_reg <= cc_reg * s3b_reg;
            ss_c_reg <= ss_reg * c3b_reg;
            ss_s_reg <= ss_reg * s3b_reg;
            sc_c_reg <= sc_reg * c3b_reg;
            sc_s_reg <= sc_reg * s3b_reg;
            cs_c_reg <= cs_reg * c3b_reg;
            cs_s_reg <= cs_reg * s3b_reg;
        end
    end

    assign sum_w = cc_c_reg - ss_s_reg;
    assign sum_x = ss_c_reg + cc_s_reg;
    assign sum_y = sc_c_reg + cs_s_reg;
    assign sum_z = cs_c_reg - sc_s_reg;

endmodule

// ===== src/euler_to_quaternion_top.sv =====
// Channel  | Handshake           | Word
// in       | in_valid, in_ready  | in_data  (pitch, yaw, roll)
// out      | out_valid, out_ready| out_data (w, x, y, z)
//
// One word is taken every cycle while the pipeline moves; a word passes through 24 CORDIC
// cells, three multiplier stages and the output register. The pipeline moves as one and
// holds only while a result waits at the output with out_ready low. Reset clears the
// valid bits only. Depends on e2q_pkg, e2q_cordic_cell and e2q_quat_mul.
module euler_to_quaternion_top
    import e2q_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int PIPE = CORDIC_STEPS + 3;

    logic            en;
    logic [PIPE-1:0] vld_reg, vld_next;
    logic            out_valid_reg, out_valid_next;
    out_word_t       out_data_reg, out_data_next;
    cordic_t         yaw_c   [0:CORDIC_STEPS];
    cordic_t         roll_c  [0:CORDIC_STEPS];
    cordic_t         pitch_c [0:CORDIC_STEPS];
    logic signed [PROD_W-1:0] sum_w, sum_x, sum_y, sum_z;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign yaw_c[0]   = cordic_start(in_data.yaw_angle);
    assign roll_c[0]  = cordic_start(in_data.roll_angle);
    assign pitch_c[0] = cordic_start(in_data.pitch_angle);

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        e2q_cordic_cell #(.STEP(i)) u_yaw
        (
            .clk(clk), .en(en), .d(yaw_c[i]), .q(yaw_c[i+1])
        );
        e2q_cordic_cell #(.STEP(i)) u_roll
        (
            .clk(clk), .en(en), .d(roll_c[i]), .q(roll_c[i+1])
        );
        e2q_cordic_cell #(.STEP(i)) u_pitch
        (
            .clk(clk), .en(en), .d(pitch_c[i]), .q(pitch_c[i+1])
        );
    end

    e2q_quat_mul u_mul
    (
        .clk(clk),
        .en(en),
        .c1(yaw_c[CORDIC_STEPS].x),
        .s1(yaw_c[CORDIC_STEPS].y),
        .c2(roll_c[CORDIC_STEPS].x),
        .s2(roll_c[CORDIC_STEPS].y),
        .c3(pitch_c[CORDIC_STEPS].x),
        .s3(pitch_c[CORDIC_STEPS].y),
        .sum_w(sum_w),
        .sum_x(sum_x),
        .sum_y(sum_y),
        .sum_z(sum_z)
    );

    always_comb
    begin
        vld_next              = {vld_reg[PIPE-2:0], in_valid};
        out_valid_next        = vld_reg[PIPE-1];
        out_data_next.quat_w  = to_out(sum_w);
        out_data_next.quat_x  = to_out(sum_x);
        out_data_next.quat_y  = to_out(sum_y);
        out_data_next.quat_z  = to_out(sum_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A waiting result must stall the input side.
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

    // An accepted word enters the first cell stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");

    // The last pipeline stage always reaches the output when moving.
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE-1] && en |=> out_valid)
        else $error("result lost at output register");

endmodule
